[sv/linear_sensor_readout_sequencer_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the line-scan sensor readout sequencer.
// They expand to concurrent assertions in simulation and to nothing in
// synthesis.
// ---------------------------------------------------------------------------
`ifndef LINEAR_SENSOR_READOUT_SEQUENCER_MACROS_SVH
`define LINEAR_SENSOR_READOUT_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define LSRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsrs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LSRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsrs assertion failed");

`else

`define LSRS_ASSERT_SAME(label, clk, rst, ante, cons)

`define LSRS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/lsrs_pkg.sv]
// ---------------------------------------------------------------------------
// lsrs_pkg
// Types and constants shared by the readout sequencer modules.
// ---------------------------------------------------------------------------
package lsrs_pkg;

   // Frame phases, one-hot encoded.
   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_PRE    = 7'b0000010,
      PH_STWAIT = 7'b0000100,
      PH_LEAD   = 7'b0001000,
      PH_INTEG  = 7'b0010000,
      PH_TAIL   = 7'b0100000,
      PH_READ   = 7'b1000000
   } phase_type;

   // Request kinds.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // Register indexes (word address bit).
   localparam logic REG_HALF_PERIOD = 1'b0;
   localparam logic REG_INTEGRATION = 1'b1;

   // Register reset values.
   localparam logic [7:0]  HALF_PERIOD_RESET = 8'd24;
   localparam logic [19:0] INTEGRATION_RESET = 20'd5000;

   // Clock counts of the fixed frame steps.
   localparam logic [19:0] CLOSE_CLOCKS  = 20'd48;
   localparam logic [19:0] SETTLE_CLOCKS = 20'd40;
   localparam logic [19:0] LEAD_CLOCKS   = 20'd3;
   localparam logic [19:0] TAIL_CLOCKS   = CLOSE_CLOCKS + SETTLE_CLOCKS;

   typedef struct packed {
      logic        kind;
      logic [11:0] video_sample;
   } req_type;

   typedef struct packed {
      logic        clock_level;
      logic        start_level;
      logic        pixel_valid;
      logic [8:0]  pixel_index;
      logic [11:0] pixel_value;
      logic        busy_res;
      logic        frame_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  half_period_ticks;
      logic [19:0] integration_clocks;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [19:0] clocks_left;
      logic [7:0]  half_tick_count;
      logic        clock_out;
      logic        start_out;
      logic [8:0]  pixel_count;
   } seq_state_type;

endpackage

[sv/lsrs_csr.sv]
// ---------------------------------------------------------------------------
// lsrs_csr
// APB-style register block holding the half period and integration length.
// ---------------------------------------------------------------------------
module lsrs_csr import lsrs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic    wr_en;
   cfg_type cfg_ff;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Register writes; the word address bit selects the register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks  <= HALF_PERIOD_RESET;
         cfg_ff.integration_clocks <= INTEGRATION_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            REG_HALF_PERIOD: cfg_ff.half_period_ticks  <= pwdata[7:0];
            REG_INTEGRATION: cfg_ff.integration_clocks <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   // Read data mux.
   always_comb begin
      case (paddr[2])
         REG_HALF_PERIOD: prdata = {24'd0, cfg_ff.half_period_ticks};
         REG_INTEGRATION: prdata = {12'd0, cfg_ff.integration_clocks};
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[sv/lsrs_step.sv]
// ---------------------------------------------------------------------------
// lsrs_step
// Next-state and result logic of the frame sequencer for one request.
// ---------------------------------------------------------------------------
module lsrs_step import lsrs_pkg::*; #(
   parameter int NUM_PIXELS = 288
) (
   input  seq_state_type cur,
   input  req_type       item,
   input  cfg_type       cfg,
   output seq_state_type nxt,
   output rsp_type       rsp
);

   localparam logic [8:0] PIX_LIMIT = 9'(NUM_PIXELS);

   logic [7:0]    hp;
   logic [7:0]    htc_inc;
   logic [19:0]   cl_dec;
   logic [19:0]   integ_n;
   logic [8:0]    pc_inc;
   seq_state_type st;
   logic          got_valid;
   logic [8:0]    got_index;
   logic          got_done;

   // A half period of zero ticks behaves as one tick.
   assign hp      = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
   assign htc_inc = cur.half_tick_count + 8'd1;
   assign cl_dec  = (cur.clocks_left != 20'd0) ? cur.clocks_left - 20'd1 : 20'd0;
   assign pc_inc  = cur.pixel_count + 9'd1;

   // Integration clocks exclude the closing clocks and saturate at zero.
   assign integ_n = (cfg.integration_clocks >= CLOSE_CLOCKS)
                    ? cfg.integration_clocks - CLOSE_CLOCKS : 20'd0;

   // Sequencer update.
   always_comb begin
      st        = cur;
      got_valid = 1'b0;
      got_index = 9'd0;
      got_done  = 1'b0;
      if (item.kind == KIND_START) begin
         // A start while a frame runs is ignored.
         if (cur.phase == PH_IDLE) begin
            st.phase           = PH_PRE;
            st.start_out       = 1'b0;
            st.half_tick_count = 8'd0;
            st.clocks_left     = 20'd1;
            st.clock_out       = 1'b1;
         end
      end else if (cur.phase != PH_IDLE) begin
         if (htc_inc < hp) begin
            st.half_tick_count = htc_inc;
         end else begin
            // End of a half period.
            st.half_tick_count = 8'd0;
            if (cur.phase == PH_STWAIT) begin
               st.phase       = PH_LEAD;
               st.clocks_left = LEAD_CLOCKS;
               st.clock_out   = 1'b1;
            end else if (cur.clock_out) begin
               st.clock_out = 1'b0;
            end else begin
               st.clocks_left = cl_dec;
               if (cl_dec != 20'd0) begin
                  st.clock_out = 1'b1;
               end else begin
                  case (cur.phase)
                     PH_PRE: begin
                        st.phase     = PH_STWAIT;
                        st.start_out = 1'b1;
                     end
                     PH_LEAD: begin
                        if (integ_n != 20'd0) begin
                           st.phase       = PH_INTEG;
                           st.clocks_left = integ_n;
                           st.clock_out   = 1'b1;
                        end else begin
                           st.start_out   = 1'b0;
                           st.phase       = PH_TAIL;
                           st.clocks_left = TAIL_CLOCKS;
                           st.clock_out   = 1'b1;
                        end
                     end
                     PH_INTEG: begin
                        st.start_out   = 1'b0;
                        st.phase       = PH_TAIL;
                        st.clocks_left = TAIL_CLOCKS;
                        st.clock_out   = 1'b1;
                     end
                     PH_TAIL: begin
                        // First pixel is sampled as its clock goes high.
                        st.phase       = PH_READ;
                        st.pixel_count = 9'd0;
                        got_valid      = 1'b1;
                        got_index      = 9'd0;
                        st.clocks_left = 20'd1;
                        st.clock_out   = 1'b1;
                     end
                     PH_READ: begin
                        st.pixel_count = pc_inc;
                        if (pc_inc >= PIX_LIMIT) begin
                           st.phase = PH_IDLE;
                           got_done = 1'b1;
                        end else begin
                           got_valid      = 1'b1;
                           got_index      = pc_inc;
                           st.clocks_left = 20'd1;
                           st.clock_out   = 1'b1;
                        end
                     end
                     default: begin
                        st.phase     = PH_IDLE;
                        st.clock_out = 1'b0;
                        st.start_out = 1'b0;
                     end
                  endcase
               end
            end
         end
      end
   end

   assign nxt = st;

   // Result fields reflect the pin levels after this request.
   always_comb begin
      rsp.clock_level = st.clock_out;
      rsp.start_level = st.start_out;
      rsp.pixel_valid = got_valid;
      rsp.pixel_index = got_index;
      rsp.pixel_value = got_valid ? item.video_sample : 12'd0;
      rsp.busy_res    = (st.phase != PH_IDLE);
      rsp.frame_done  = got_done;
   end

endmodule

[sv/linear_sensor_readout_sequencer.sv]
// ---------------------------------------------------------------------------
// linear_sensor_readout_sequencer
// Clock and start-pulse timing generator for a line-scan sensor with
// per-pixel video sample capture.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_valid/ready    req_data  (kind, video_sample)
//   rsp_      out        rsp_valid/ready    rsp_data  (pins, pixel, status)
//   APB       in         psel/penable       half_period_ticks, integration
//
// Each request passes an input register, then the sequencer logic, then the
// result register. It takes one request per cycle while the result is not
// stalled, as the frame state is updated between those two registers.
// Reset is synchronous; it clears the frame state and loads register defaults.
// A stalled result holds the state and the input register; the input
// register still accepts one request while the result waits.
// ---------------------------------------------------------------------------
`include "linear_sensor_readout_sequencer_macros.svh"

module linear_sensor_readout_sequencer import lsrs_pkg::*; #(
   parameter int NUM_PIXELS = 288
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type       cfg;
   logic          in_valid_ff;
   req_type       in_data_ff;
   logic          advance;
   seq_state_type st_ff;
   seq_state_type st_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;

   // Configuration registers.
   lsrs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The held request moves on when the result register is free or drains.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Sequencer logic.
   lsrs_step #(
      .NUM_PIXELS (NUM_PIXELS)
   ) u_step (
      .cur  (st_ff),
      .item (in_data_ff),
      .cfg  (cfg),
      .nxt  (st_in),
      .rsp  (rsp_data_in)
   );

   // Frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase           <= PH_IDLE;
         st_ff.clocks_left     <= 20'd0;
         st_ff.half_tick_count <= 8'd0;
         st_ff.clock_out       <= 1'b0;
         st_ff.start_out       <= 1'b0;
         st_ff.pixel_count     <= 9'd0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Both pins are low whenever no frame runs.
   `LSRS_ASSERT_SAME(a_idle_pins_low, clock, reset, st_ff.phase == PH_IDLE, !st_ff.clock_out && !st_ff.start_out)

   // Start is high only from the start pulse through integration.
   `LSRS_ASSERT_SAME(a_start_window, clock, reset, st_ff.start_out, st_ff.phase == PH_STWAIT || st_ff.phase == PH_LEAD || st_ff.phase == PH_INTEG)

   // A start request taken while idle opens a frame with the clock high.
   `LSRS_ASSERT_NEXT(a_frame_open, clock, reset, advance && in_data_ff.kind == KIND_START && st_ff.phase == PH_IDLE, st_ff.phase == PH_PRE && st_ff.clock_out)

   // A captured pixel shown on the result belongs to the readout phase.
   `LSRS_ASSERT_SAME(a_pixel_in_read, clock, reset, rsp_valid_ff && rsp_data_ff.pixel_valid, st_ff.phase == PH_READ)

endmodule
